/* hdl/rsda_pkg.sv */
// ----------------------------------------------------------------------------
// rsda_pkg
// Shared widths, constants and controller/datapath interface types for the
// return standard deviation accumulator.
// ----------------------------------------------------------------------------
package rsda_pkg;

   // price and result widths
   localparam int PriceW  = 32;
   localparam int CountW  = 12;
   localparam int SumW    = 48;
   localparam int SqSumW  = 64;
   localparam int StdW    = 32;

   // shared divider: 76-bit dividend, 32-bit divisor
   localparam int DivW    = 76;
   // serial multiplier: 48-bit multiplier, 96-bit product
   localparam int MulW    = 48;
   localparam int ProdW   = 96;
   // square root over a 64-bit radicand
   localparam int SqrtW   = 64;
   localparam int StepW   = 7;

   localparam int DefMaxSamples = 4096;
   localparam logic [CountW-1:0] MinReturnsReset = 12'd3;
   localparam logic [CountW-1:0] MinReturnsFloor = 12'd2;

   // Q4.28 unity and return saturation point
   localparam logic [31:0] OneQ28  = 32'h1000_0000;
   localparam logic [31:0] RetMax  = 32'h7FFF_FFFF;
   localparam logic [DivW-1:0] RetSatQ = 76'h8FFF_FFFF;

   // controller -> datapath commands
   typedef struct packed {
      logic cap_item;
      logic div_load_ret;
      logic div_load_var;
      logic div_step;
      logic ret_load;
      logic sq_mul;
      logic sq_acc;
      logic prev_update;
      logic mul_load_a;
      logic mul_load_b;
      logic mul_step;
      logic save_a;
      logic sqrt_load;
      logic sqrt_step;
      logic out_load;
      logic out_ok;
      logic out_sat;
      logic series_clear;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic form_ret;
      logic cnt_zero;
      logic item_last;
      logic enough;
      logic d_pos;
      logic q_big;
      logic out_free;
   } stat_type;

endpackage

/* hdl/rsda_ctrl.sv */
// ----------------------------------------------------------------------------
// rsda_ctrl
// Sequencer: steps an item that forms a return through division, squaring
// and accumulation, and on the last sample through the deviation computation.
// ----------------------------------------------------------------------------
module rsda_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsda_pkg::stat_type stat,
   output rsda_pkg::cmd_type  cmd
);
   import rsda_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_EVAL = 13'b0000000000010,
      S_RDIV = 13'b0000000000100,
      S_RSQ  = 13'b0000000001000,
      S_RACC = 13'b0000000010000,
      S_UPD  = 13'b0000000100000,
      S_FCHK = 13'b0000001000000,
      S_MULA = 13'b0000010000000,
      S_MULB = 13'b0000100000000,
      S_VDIV = 13'b0001000000000,
      S_SQRT = 13'b0010000000000,
      S_EMIT = 13'b0100000000000,
      S_SPARE = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      sat_ff, sat_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      sat_in   = sat_ff;
      cmd      = '0;
      cmd.out_ok  = ok_ff;
      cmd.out_sat = sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_item = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.form_ret) begin
               cmd.div_load_ret = 1'b1;
               state_in = S_RDIV;
            end else begin
               state_in = S_UPD;
            end
         end
         S_RDIV: begin
            if (stat.cnt_zero) begin
               cmd.ret_load = 1'b1;
               state_in = S_RSQ;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_RSQ: begin
            cmd.sq_mul = 1'b1;
            state_in = S_RACC;
         end
         S_RACC: begin
            cmd.sq_acc = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.prev_update = 1'b1;
            state_in = stat.item_last ? S_FCHK : S_IDLE;
         end
         S_FCHK: begin
            if (stat.enough) begin
               cmd.mul_load_a = 1'b1;
               state_in = S_MULA;
            end else begin
               ok_in  = 1'b0;
               sat_in = 1'b0;
               state_in = S_EMIT;
            end
         end
         S_MULA: begin
            if (stat.cnt_zero) begin
               cmd.save_a     = 1'b1;
               cmd.mul_load_b = 1'b1;
               state_in = S_MULB;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_MULB: begin
            if (stat.cnt_zero) begin
               if (stat.d_pos) begin
                  cmd.div_load_var = 1'b1;
                  state_in = S_VDIV;
               end else begin
                  ok_in  = 1'b0;
                  sat_in = 1'b0;
                  state_in = S_EMIT;
               end
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_VDIV: begin
            if (stat.cnt_zero) begin
               if (stat.q_big) begin
                  ok_in  = 1'b1;
                  sat_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  cmd.sqrt_load = 1'b1;
                  state_in = S_SQRT;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_SQRT: begin
            if (stat.cnt_zero) begin
               ok_in  = 1'b1;
               sat_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.series_clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ok_ff    <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

/* hdl/rsda_dp.sv */
// ----------------------------------------------------------------------------
// rsda_dp
// Datapath: series state, shared restoring divider, serial multiplier,
// digit-by-digit square root, return squarer and the result register.
// ----------------------------------------------------------------------------
module rsda_dp #(
   parameter int MAX_SAMPLES = rsda_pkg::DefMaxSamples
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rsda_pkg::PriceW-1:0] req_price,
   input  logic                        req_price_valid,
   input  logic                        req_series_last,
   input  logic                        csr_wr_en,
   input  logic [rsda_pkg::CountW-1:0] csr_wr_data,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [rsda_pkg::StdW-1:0]   rsp_std_dev,
   output logic                        rsp_std_valid,
   output logic [rsda_pkg::CountW-1:0] rsp_return_count,
   input  rsda_pkg::cmd_type           cmd,
   output rsda_pkg::stat_type          stat
);
   import rsda_pkg::*;

   localparam int CapInt = (MAX_SAMPLES - 1 < 4095) ? (MAX_SAMPLES - 1) : 4095;
   localparam logic [CountW-1:0] CountCap = CountW'(CapInt);

   // configuration and captured item
   logic [CountW-1:0] min_ret_ff;
   logic [PriceW-1:0] item_price_ff;
   logic              item_valid_ff;
   logic              item_last_ff;

   // series state
   logic [PriceW-1:0]        prev_price_ff;
   logic                     prev_valid_ff;
   logic signed [SumW-1:0]   ret_sum_ff;
   logic [SqSumW-1:0]        sq_sum_ff;
   logic [CountW-1:0]        count_ff;

   // shared step counter
   logic [StepW-1:0] cnt_ff;

   // divider
   logic [DivW-1:0]  div_q_ff;
   logic [32:0]      div_r_ff;
   logic [31:0]      div_d_ff;
   logic [32:0]      div_sh;
   logic [33:0]      div_diff;

   // return and square
   logic signed [31:0] ret_ff;
   logic [31:0]        ret_mag;
   logic [63:0]        sq_ff;
   logic [64:0]        sq_add;
   logic [31:0]        ret_val;

   // serial multiplier
   logic [ProdW-1:0] acc_ff;
   logic [ProdW-1:0] mcand_ff;
   logic [MulW-1:0]  mplier_ff;
   logic [ProdW-1:0] a_ff;
   logic [SumW-1:0]  sum_abs;
   logic [ProdW-1:0] d_diff;
   logic [23:0]      nn1;

   // square root
   logic [SqrtW-1:0] sq_x_ff;
   logic [33:0]      sq_rem_ff;
   logic [31:0]      sq_root_ff;
   logic [34:0]      sq_sh;
   logic [34:0]      sq_trial;

   // output register
   logic              out_valid_ff;
   logic [StdW-1:0]   out_std_ff;
   logic              out_ok_ff;
   logic [CountW-1:0] out_cnt_ff;

   logic [CountW-1:0] need;

   // combinational helpers
   always_comb begin
      div_sh   = {div_r_ff[31:0], div_q_ff[DivW-1]};
      div_diff = {1'b0, div_sh} - {2'b00, div_d_ff};
      ret_val  = (div_q_ff >= RetSatQ) ? RetMax : (div_q_ff[31:0] - OneQ28);
      ret_mag  = ret_ff[31] ? (32'd0 - ret_ff) : ret_ff;
      sq_add   = {1'b0, sq_sum_ff} + {1'b0, sq_ff};
      sum_abs  = ret_sum_ff[SumW-1] ? (SumW'(0) - ret_sum_ff) : ret_sum_ff;
      d_diff   = a_ff - acc_ff;
      nn1      = 24'(count_ff) * 24'(count_ff - 12'd1);
      sq_sh    = {sq_rem_ff[32:0], sq_x_ff[SqrtW-1 -: 2]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
      need     = (min_ret_ff < MinReturnsFloor) ? MinReturnsFloor : min_ret_ff;
   end

   // status to controller
   always_comb begin
      stat.form_ret  = item_valid_ff && prev_valid_ff && (prev_price_ff != '0)
                       && (count_ff < CountCap);
      stat.cnt_zero  = (cnt_ff == '0);
      stat.item_last = item_last_ff;
      stat.enough    = (count_ff >= need);
      stat.d_pos     = (a_ff > acc_ff);
      stat.q_big     = (div_q_ff[DivW-1:SqrtW] != '0);
      stat.out_free  = !out_valid_ff || !rsp_stall;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ret_ff    <= MinReturnsReset;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_ret_ff <= csr_wr_data;
         end
         // step counter
         if (cmd.div_load_ret || cmd.div_load_var) begin
            cnt_ff <= StepW'(DivW);
         end else if (cmd.mul_load_a || cmd.mul_load_b) begin
            cnt_ff <= StepW'(MulW);
         end else if (cmd.sqrt_load) begin
            cnt_ff <= StepW'(SqrtW / 2);
         end else if (cmd.div_step || cmd.mul_step || cmd.sqrt_step) begin
            cnt_ff <= cnt_ff - StepW'(1);
         end
         if (cmd.sq_acc) begin
            count_ff <= count_ff + 12'd1;
         end
         if (cmd.prev_update) begin
            prev_valid_ff <= item_valid_ff;
         end
         if (cmd.series_clear) begin
            prev_valid_ff <= 1'b0;
            count_ff      <= '0;
         end
         // result handshake
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ret_sum_ff    <= '0;
         sq_sum_ff     <= '0;
         prev_price_ff <= '0;
      end else begin
         if (cmd.cap_item) begin
            item_price_ff <= req_price;
            item_valid_ff <= req_price_valid;
            item_last_ff  <= req_series_last;
         end
         // shared divider
         if (cmd.div_load_ret) begin
            div_q_ff <= {16'd0, item_price_ff, 28'd0};
            div_r_ff <= '0;
            div_d_ff <= prev_price_ff;
         end else if (cmd.div_load_var) begin
            div_q_ff <= d_diff[DivW-1:0];
            div_r_ff <= '0;
            div_d_ff <= {8'd0, nn1};
         end else if (cmd.div_step) begin
            if (!div_diff[33]) begin
               div_r_ff <= div_diff[32:0];
               div_q_ff <= {div_q_ff[DivW-2:0], 1'b1};
            end else begin
               div_r_ff <= div_sh;
               div_q_ff <= {div_q_ff[DivW-2:0], 1'b0};
            end
         end
         // return, square and accumulate
         if (cmd.ret_load) begin
            ret_ff <= ret_val;
         end
         if (cmd.sq_mul) begin
            sq_ff <= 64'(ret_mag) * 64'(ret_mag);
         end
         if (cmd.sq_acc) begin
            ret_sum_ff <= ret_sum_ff + {{(SumW-32){ret_ff[31]}}, ret_ff};
            sq_sum_ff  <= sq_add[64] ? '1 : sq_add[63:0];
         end
         if (cmd.prev_update && item_valid_ff) begin
            prev_price_ff <= item_price_ff;
         end
         if (cmd.series_clear) begin
            ret_sum_ff    <= '0;
            sq_sum_ff     <= '0;
            prev_price_ff <= '0;
         end
         // serial multiplier
         if (cmd.save_a) begin
            a_ff <= acc_ff;
         end
         if (cmd.mul_load_a) begin
            acc_ff    <= '0;
            mcand_ff  <= {32'd0, sq_sum_ff};
            mplier_ff <= {36'd0, count_ff};
         end else if (cmd.mul_load_b) begin
            acc_ff    <= '0;
            mcand_ff  <= {48'd0, sum_abs};
            mplier_ff <= sum_abs;
         end else if (cmd.mul_step) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[ProdW-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[MulW-1:1]};
         end
         // square root, two radicand bits per step
         if (cmd.sqrt_load) begin
            sq_x_ff    <= div_q_ff[SqrtW-1:0];
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
         end else if (cmd.sqrt_step) begin
            sq_x_ff <= {sq_x_ff[SqrtW-3:0], 2'b00};
            if (sq_sh >= sq_trial) begin
               sq_rem_ff  <= 34'(sq_sh - sq_trial);
               sq_root_ff <= {sq_root_ff[30:0], 1'b1};
            end else begin
               sq_rem_ff  <= sq_sh[33:0];
               sq_root_ff <= {sq_root_ff[30:0], 1'b0};
            end
         end
         // result
         if (cmd.out_load) begin
            out_ok_ff  <= cmd.out_ok;
            out_cnt_ff <= count_ff;
            if (!cmd.out_ok) begin
               out_std_ff <= '0;
            end else if (cmd.out_sat) begin
               out_std_ff <= '1;
            end else begin
               out_std_ff <= sq_root_ff;
            end
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_std_dev      = out_std_ff;
   assign rsp_std_valid    = out_ok_ff;
   assign rsp_return_count = out_cnt_ff;

endmodule

/* hdl/return_std_dev_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// return_std_dev_accumulator_unit
// Accumulates simple returns of a price series and reports their sample
// standard deviation on the series' last sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (req_*) carry one Q16.16 price, a present flag and a
//   last-of-series flag. req_stall is low only while the block is idle.
//   A sample that forms a return passes through a 76-step radix-2 divider,
//   then squaring and accumulation; one that forms none skips all three.
//   Given enough returns, the last sample adds the deviation: two 48-step
//   serial multiplies, a 76-step variance divide and a 32-step square root.
//   Results (rsp_*) sit in an output register; the next item is accepted
//   while a result waits. If the receiver stalls, a new result waits
//   in the controller until the register frees, holding off input.
//   csr_wr_en/csr_wr_data set min_returns; the user sets it only while idle,
//   which the block does not enforce. Reset clears the series and sets
//   min_returns to 3; it takes effect in the next cycle.
// ----------------------------------------------------------------------------
module return_std_dev_accumulator_unit #(
   parameter int MAX_SAMPLES = rsda_pkg::DefMaxSamples
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rsda_pkg::PriceW-1:0] req_price,
   input  logic                        req_price_valid,
   input  logic                        req_series_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rsda_pkg::StdW-1:0]   rsp_std_dev,
   output logic                        rsp_std_valid,
   output logic [rsda_pkg::CountW-1:0] rsp_return_count,
   input  logic                        csr_wr_en,
   input  logic [rsda_pkg::CountW-1:0] csr_wr_data
);
   import rsda_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   rsda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   rsda_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_price        (req_price),
      .req_price_valid  (req_price_valid),
      .req_series_last  (req_series_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_std_valid    (rsp_std_valid),
      .rsp_return_count (rsp_return_count),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
